// File: hw/rtl/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Field widths of the pixel ports
  localparam int HUE_W = 16;
  localparam int SAT_W = 13;
  localparam int VAL_W = 20;

  // Hue circle
  localparam int DEG_FULL   = 360;
  localparam int DEG_SECTOR = 60;
  localparam int HUE_MOD_W  = 9;   // hue mod 360 fits 0..359
  localparam int REM_W      = 6;   // hue mod 60 fits 0..59

  // hue / 360 as multiply by ceil(2^24 / 360); exact for every 16-bit hue
  localparam int              HUE_RECIP_W     = 16;
  localparam logic [15:0]     HUE_RECIP       = 16'd46604;
  localparam int              HUE_RECIP_SHIFT = 24;
  localparam int              HUE_PROD_W      = HUE_W + HUE_RECIP_W;
  localparam int              HUE_Q_W         = HUE_PROD_W - HUE_RECIP_SHIFT;

  // c / 255 as multiply by ceil(2^28 / 255); exact for every 20-bit channel
  localparam int              DIV255_RECIP_W = 21;
  localparam logic [20:0]     DIV255_RECIP   = 21'd1052689;
  localparam int              DIV255_SHIFT   = 28;
  localparam int              DIV255_PROD_W  = VAL_W + DIV255_RECIP_W;
  localparam int              DIV255_Q_W     = DIV255_PROD_W - DIV255_SHIFT;

  // Sixty-degree sector of the hue circle
  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_t;

  // Control that travels with each beat down the pipe
  typedef struct packed {
    logic    valid;
    logic    grey;
    sector_t sector;
  } beat_ctl_t;

  // First degree of a sector
  function automatic logic [HUE_MOD_W-1:0] sector_base(sector_t s);
    logic [HUE_MOD_W-1:0] base;
    unique case (s)
      SECTOR_0: base = HUE_MOD_W'(0 * DEG_SECTOR);
      SECTOR_1: base = HUE_MOD_W'(1 * DEG_SECTOR);
      SECTOR_2: base = HUE_MOD_W'(2 * DEG_SECTOR);
      SECTOR_3: base = HUE_MOD_W'(3 * DEG_SECTOR);
      SECTOR_4: base = HUE_MOD_W'(4 * DEG_SECTOR);
      SECTOR_5: base = HUE_MOD_W'(5 * DEG_SECTOR);
      default:  base = '0;
    endcase
    return base;
  endfunction

endpackage

// File: hw/rtl/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps

// HSV to RGB pixel converter. A pixel is taken on every clock edge where start
// is high; busy is always low, so a pixel may be offered every cycle. Each
// pixel comes out as one beat on red/green/blue with done high for that
// single cycle; the receiver cannot stall, so it must take every beat when done
// is high. In the pipeline, four stages reduce the hue modulo 360 and look up
// the sector fraction, four form s*f, the p/q/t factors, the three value
// products and the sector select, and two apply the divide-by-255 rule and
// register the outputs. Saturation and value are Q.FRAC_BITS unsigned; zero
// saturation returns the value unchanged.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] hue_degrees,
  input  logic [SAT_W-1:0] saturation,
  input  logic [VAL_W-1:0] brightness,
  output logic             done,
  output logic [VAL_W-1:0] red,
  output logic [VAL_W-1:0] green,
  output logic [VAL_W-1:0] blue
);

  beat_ctl_t             hue_ctl;
  logic [FRAC_BITS-1:0]  hue_frac;
  logic [SAT_W-1:0]      hue_sat;
  logic [VAL_W-1:0]      hue_val;

  beat_ctl_t             mix_ctl;
  logic [2:0][VAL_W-1:0] mix_chan;

  logic [2:0][VAL_W-1:0] rgb;

  // Pipeline never holds off a pixel
  assign busy = 1'b0;

  // Hue reduction, sector and fraction
  hsv2rgb_hue #(
    .FRAC_BITS (FRAC_BITS)
  ) u_hue (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start),
    .hue_degrees (hue_degrees),
    .saturation  (saturation),
    .brightness  (brightness),
    .ctl         (hue_ctl),
    .frac        (hue_frac),
    .sat         (hue_sat),
    .val         (hue_val)
  );

  // p, q, t and channel select
  hsv2rgb_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (hue_ctl),
    .frac    (hue_frac),
    .sat     (hue_sat),
    .val     (hue_val),
    .out_ctl (mix_ctl),
    .chan    (mix_chan)
  );

  // Divide-by-255 rule and output register
  hsv2rgb_clamp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_clamp (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (mix_ctl),
    .chan      (mix_chan),
    .out_valid (done),
    .rgb       (rgb)
  );

  assign red   = rgb[0];
  assign green = rgb[1];
  assign blue  = rgb[2];

endmodule

// File: hw/rtl/hsv2rgb_hue.sv
`timescale 1ns / 1ps

module hsv2rgb_hue
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [HUE_W-1:0]     hue_degrees,
  input  logic [SAT_W-1:0]     saturation,
  input  logic [VAL_W-1:0]     brightness,
  output beat_ctl_t            ctl,
  output logic [FRAC_BITS-1:0] frac,
  output logic [SAT_W-1:0]     sat,
  output logic [VAL_W-1:0]     val
);

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int TAB_DEPTH = 1 << REM_W;

  // Fraction table: (rem << FRAC_BITS) / 60, worked out at elaboration
  logic [FRAC_BITS-1:0] frac_tab [TAB_DEPTH];

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_frac_tab
    if (i < DEG_SECTOR) begin : g_used
      assign frac_tab[i] = FRAC_BITS'((i * ONE) / DEG_SECTOR);
    end else begin : g_unused
      assign frac_tab[i] = '0;
    end
  end

  // Stage 1: hue times reciprocal of 360
  logic                  v1, grey1;
  logic [HUE_PROD_W-1:0] prod1;
  logic [HUE_W-1:0]      hue1;
  logic [SAT_W-1:0]      sat1;
  logic [VAL_W-1:0]      val1;

  // Stage 2: hue mod 360
  logic                  v2, grey2;
  logic [HUE_MOD_W-1:0]  hmod2;
  logic [SAT_W-1:0]      sat2;
  logic [VAL_W-1:0]      val2;

  // Stage 3: sector and remainder in the sector
  logic                  v3, grey3;
  sector_t               sector3;
  logic [REM_W-1:0]      rem3;
  logic [SAT_W-1:0]      sat3;
  logic [VAL_W-1:0]      val3;

  // Stage 4: fraction
  logic                  v4, grey4;
  sector_t               sector4;
  logic [FRAC_BITS-1:0]  frac4;
  logic [SAT_W-1:0]      sat4;
  logic [VAL_W-1:0]      val4;

  // Combinational pieces between stages
  logic [HUE_Q_W-1:0]    hue_q;
  logic [HUE_W:0]        hue_q360;
  logic [HUE_W:0]        hue_diff;
  sector_t               sector_next;
  logic [HUE_MOD_W-1:0]  rem_wide;

  always_comb begin
    hue_q    = prod1[HUE_PROD_W-1 -: HUE_Q_W];
    hue_q360 = (HUE_W + 1)'(hue_q) * (HUE_W + 1)'(DEG_FULL);
    hue_diff = (HUE_W + 1)'(hue1) - hue_q360;
  end

  // Sector by compare against sector boundaries
  always_comb begin
    if (hmod2 >= HUE_MOD_W'(5 * DEG_SECTOR)) begin
      sector_next = SECTOR_5;
    end else if (hmod2 >= HUE_MOD_W'(4 * DEG_SECTOR)) begin
      sector_next = SECTOR_4;
    end else if (hmod2 >= HUE_MOD_W'(3 * DEG_SECTOR)) begin
      sector_next = SECTOR_3;
    end else if (hmod2 >= HUE_MOD_W'(2 * DEG_SECTOR)) begin
      sector_next = SECTOR_2;
    end else if (hmod2 >= HUE_MOD_W'(1 * DEG_SECTOR)) begin
      sector_next = SECTOR_1;
    end else begin
      sector_next = SECTOR_0;
    end
    rem_wide = hmod2 - sector_base(sector_next);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    prod1   <= HUE_PROD_W'(hue_degrees) * HUE_PROD_W'(HUE_RECIP);
    hue1    <= hue_degrees;
    sat1    <= saturation;
    val1    <= brightness;
    grey1   <= (saturation == '0);

    hmod2   <= hue_diff[HUE_MOD_W-1:0];
    sat2    <= sat1;
    val2    <= val1;
    grey2   <= grey1;

    sector3 <= sector_next;
    rem3    <= rem_wide[REM_W-1:0];
    sat3    <= sat2;
    val3    <= val2;
    grey3   <= grey2;

    sector4 <= sector3;
    frac4   <= frac_tab[rem3];
    sat4    <= sat3;
    val4    <= val3;
    grey4   <= grey3;
  end

  assign ctl.valid  = v4;
  assign ctl.grey   = grey4;
  assign ctl.sector = sector4;
  assign frac       = frac4;
  assign sat        = sat4;
  assign val        = val4;

endmodule

// File: hw/rtl/hsv2rgb_mix.sv
`timescale 1ns / 1ps

module hsv2rgb_mix
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  beat_ctl_t                  in_ctl,
  input  logic [FRAC_BITS-1:0]       frac,
  input  logic [SAT_W-1:0]           sat,
  input  logic [VAL_W-1:0]           val,
  output beat_ctl_t                  out_ctl,
  output logic [2:0][VAL_W-1:0]      chan
);

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int FW     = FRAC_BITS + 1;           // holds 0..ONE
  localparam int EW     = (FW > SAT_W) ? FW : SAT_W;
  localparam int SF_PW  = SAT_W + FRAC_BITS;
  localparam int SFC_PW = SAT_W + FW;
  localparam int VAL_PW = VAL_W + FW;

  // ONE - x, floored at zero
  function automatic logic [FW-1:0] one_minus(logic [SAT_W-1:0] x);
    logic [EW-1:0] xe;
    logic [EW-1:0] oe;
    logic [FW-1:0] res;
    xe = EW'(x);
    oe = EW'(ONE);
    if (xe >= oe) begin
      res = '0;
    end else begin
      res = FW'(oe - xe);
    end
    return res;
  endfunction

  // Stage 5: s*f and s*(1-f)
  beat_ctl_t             c5;
  logic [SF_PW-1:0]      sf_prod5;
  logic [SFC_PW-1:0]     sfc_prod5;
  logic [SAT_W-1:0]      sat5;
  logic [VAL_W-1:0]      val5;

  // Stage 6: scale factors for p, q, t
  beat_ctl_t             c6;
  logic [FW-1:0]         fp6, fq6, ft6;
  logic [VAL_W-1:0]      val6;

  // Stage 7: p, q, t
  beat_ctl_t             c7;
  logic [VAL_PW-1:0]     p_prod7, q_prod7, t_prod7;
  logic [VAL_W-1:0]      val7;

  // Stage 8: channel select
  beat_ctl_t             c8;
  logic [2:0][VAL_W-1:0] chan8;

  logic [FW-1:0]         one_less_f;
  logic [SAT_W-1:0]      sf5, sfc5;
  logic [VAL_W-1:0]      p7, q7, t7;
  logic [2:0][VAL_W-1:0] chan_next;

  always_comb begin
    one_less_f = FW'(ONE) - FW'(frac);
    sf5        = sf_prod5[FRAC_BITS +: SAT_W];
    sfc5       = sfc_prod5[FRAC_BITS +: SAT_W];
    p7         = p_prod7[FRAC_BITS +: VAL_W];
    q7         = q_prod7[FRAC_BITS +: VAL_W];
    t7         = t_prod7[FRAC_BITS +: VAL_W];
  end

  // Pick channels per sector; index 0 red, 1 green, 2 blue
  always_comb begin
    unique case (c7.sector)
      SECTOR_0: chan_next = {p7,   t7,   val7};
      SECTOR_1: chan_next = {p7,   val7, q7};
      SECTOR_2: chan_next = {t7,   val7, p7};
      SECTOR_3: chan_next = {val7, q7,   p7};
      SECTOR_4: chan_next = {val7, p7,   t7};
      SECTOR_5: chan_next = {q7,   p7,   val7};
      default:  chan_next = {q7,   p7,   val7};
    endcase
  end

  // Valid bits under reset, payload free running
  always_ff @(posedge clk) begin
    if (rst) begin
      c5.valid <= 1'b0;
      c6.valid <= 1'b0;
      c7.valid <= 1'b0;
      c8.valid <= 1'b0;
    end else begin
      c5.valid <= in_ctl.valid;
      c6.valid <= c5.valid;
      c7.valid <= c6.valid;
      c8.valid <= c7.valid;
    end

    c5.grey   <= in_ctl.grey;
    c5.sector <= in_ctl.sector;
    sf_prod5  <= SF_PW'(sat) * SF_PW'(frac);
    sfc_prod5 <= SFC_PW'(sat) * SFC_PW'(one_less_f);
    sat5      <= sat;
    val5      <= val;

    c6.grey   <= c5.grey;
    c6.sector <= c5.sector;
    fp6       <= one_minus(sat5);
    fq6       <= one_minus(sf5);
    ft6       <= one_minus(sfc5);
    val6      <= val5;

    c7.grey   <= c6.grey;
    c7.sector <= c6.sector;
    p_prod7   <= VAL_PW'(val6) * VAL_PW'(fp6);
    q_prod7   <= VAL_PW'(val6) * VAL_PW'(fq6);
    t_prod7   <= VAL_PW'(val6) * VAL_PW'(ft6);
    val7      <= val6;

    c8.grey   <= c7.grey;
    c8.sector <= c7.sector;
    chan8     <= chan_next;
  end

  assign out_ctl = c8;
  assign chan    = chan8;

endmodule

// File: hw/rtl/hsv2rgb_clamp.sv
`timescale 1ns / 1ps

module hsv2rgb_clamp
  import hsv2rgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  beat_ctl_t             in_ctl,
  input  logic [2:0][VAL_W-1:0] chan,
  output logic                  out_valid,
  output logic [2:0][VAL_W-1:0] rgb
);

  localparam int ONE = 1 << FRAC_BITS;

  // Stage 9: channel times reciprocal of 255
  logic                       v9, grey9;
  logic [2:0]                 over9;
  logic [2:0][VAL_W-1:0]      chan9;
  logic [DIV255_PROD_W-1:0]   prod9 [3];

  // Stage 10: output register
  logic                       v10;
  logic [2:0][VAL_W-1:0]      rgb10;
  logic [2:0][VAL_W-1:0]      rgb_next;

  // Channels above 1.0 take the quotient, grey passes through untouched
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (over9[i] && !grey9) begin
        rgb_next[i] = VAL_W'(prod9[i][DIV255_SHIFT +: DIV255_Q_W]);
      end else begin
        rgb_next[i] = chan9[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v9  <= in_ctl.valid;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    grey9 <= in_ctl.grey;
    chan9 <= chan;
    for (int i = 0; i < 3; i++) begin
      over9[i] <= (chan[i] > VAL_W'(ONE));
      prod9[i] <= DIV255_PROD_W'(chan[i]) * DIV255_PROD_W'(DIV255_RECIP);
    end
    rgb10 <= rgb_next;
  end

  assign out_valid = v10;
  assign rgb       = rgb10;

endmodule

// File: tb/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  localparam int FRAC         = 12;
  localparam longint ONE_Q    = longint'(1) << FRAC;
  localparam int PIPE_DEPTH   = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_BEATS = 1850;

  // One pixel waiting to be offered, with the chance of an idle cycle before it
  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [VAL_W-1:0] val;
    int               gap_pct;
  } pixel_t;

  typedef struct {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [HUE_W-1:0] hue_degrees = '0;
  logic [SAT_W-1:0] saturation = '0;
  logic [VAL_W-1:0] brightness = '0;
  logic             done;
  logic [VAL_W-1:0] red;
  logic [VAL_W-1:0] green;
  logic [VAL_W-1:0] blue;

  pixel_t pixels_pending[$];
  rgb_t   expected_rgb[$];
  pixel_t next_pixel;
  rgb_t   want_rgb;
  int     failures = 0;
  int     cycle_count = 0;

  hsv_to_rgb_converter #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue_degrees(hue_degrees),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // v * factor in Q.FRAC, truncated; a factor at or below zero gives 0
  function automatic longint scale_value(longint v, longint factor);
    if (factor <= 0) begin
      return 0;
    end
    return (v * factor) >> FRAC;
  endfunction

  // Channels above 1.0 are divided by 255, truncated
  function automatic logic [VAL_W-1:0] clamp_channel(longint c);
    if (c > ONE_Q) begin
      return VAL_W'(c / 255);
    end
    return VAL_W'(c);
  endfunction

  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue_in, logic [SAT_W-1:0] sat_in,
                                       logic [VAL_W-1:0] val_in);
    longint  hue;
    longint  sat;
    longint  val;
    longint  frac;
    longint  sf;
    longint  sfc;
    longint  p;
    longint  q;
    longint  t;
    longint  r;
    longint  g;
    longint  b;
    sector_t sector;
    rgb_t    res;
    hue    = longint'(hue_in) % DEG_FULL;
    sat    = longint'(sat_in);
    val    = longint'(val_in);
    sector = sector_t'(hue / DEG_SECTOR);
    frac   = ((hue % DEG_SECTOR) << FRAC) / DEG_SECTOR;
    sf     = (sat * frac) >> FRAC;
    sfc    = (sat * (ONE_Q - frac)) >> FRAC;
    // grey passes the value through with no clamp
    if (sat == 0) begin
      res.red   = val_in;
      res.green = val_in;
      res.blue  = val_in;
      return res;
    end
    p = scale_value(val, ONE_Q - sat);
    q = scale_value(val, ONE_Q - sf);
    t = scale_value(val, ONE_Q - sfc);
    case (sector)
      SECTOR_0: begin r = val; g = t;   b = p;   end
      SECTOR_1: begin r = q;   g = val; b = p;   end
      SECTOR_2: begin r = p;   g = val; b = t;   end
      SECTOR_3: begin r = p;   g = q;   b = val; end
      SECTOR_4: begin r = t;   g = p;   b = val; end
      default:  begin r = val; g = p;   b = q;   end
    endcase
    res.red   = clamp_channel(r);
    res.green = clamp_channel(g);
    res.blue  = clamp_channel(b);
    return res;
  endfunction

  task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val, int gap);
    pixel_t px;
    px.hue     = HUE_W'(hue);
    px.sat     = SAT_W'(sat);
    px.val     = VAL_W'(val);
    px.gap_pct = gap;
    pixels_pending.push_back(px);
  endtask

  task automatic check_channel(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Random pixel biased toward sector edges, saturation extremes and the 1.0 knee
  task automatic add_random_pixel(int gap);
    int unsigned hue;
    int unsigned sat;
    int unsigned val;
    case ($urandom_range(3))
      0: hue = $urandom & 16'hFFFF;
      1: hue = $urandom_range(5) * DEG_SECTOR + ($urandom_range(1) ? 0 : DEG_SECTOR - 1)
               + DEG_FULL * $urandom_range(181);
      2: hue = $urandom_range(DEG_FULL - 1);
      default: hue = $urandom_range(16'hFFFF);
    endcase
    case ($urandom_range(9))
      0: sat = 0;
      1: sat = 4096;
      2: sat = $urandom_range(4097, 8191);
      3: sat = $urandom & 13'h1FFF;
      default: sat = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(9))
      0: val = 0;
      1: val = $urandom_range(4096);
      2: val = $urandom_range(4090, 4100);
      3: val = 20'hFFFFF;
      4: val = 1044480;
      default: val = $urandom & 20'hFFFFF;
    endcase
    add_pixel(hue, sat, val, gap);
  endtask

  // Stimulus and end of run
  initial begin
    int gap_by_phase[4];
    gap_by_phase = '{0, 83, 0, 27};

    // directed: sector edges, hue wrap, grey, saturation at and above one
    add_pixel(0, 4096, 4096, 0);
    add_pixel(59, 2048, 4096, 0);
    add_pixel(60, 2048, 4096, 0);
    add_pixel(119, 3000, 2000, 0);
    add_pixel(120, 3000, 2000, 0);
    add_pixel(180, 1000, 4000, 0);
    add_pixel(240, 1000, 4000, 0);
    add_pixel(300, 4095, 4096, 0);
    add_pixel(359, 1, 4096, 0);
    add_pixel(360, 2048, 3000, 0);
    add_pixel(65535, 2048, 3000, 0);
    add_pixel(200, 0, 20'hFFFFF, 0);
    add_pixel(30, 0, 1044480, 0);
    add_pixel(45, 0, 0, 0);
    add_pixel(90, 8191, 4096, 0);
    add_pixel(270, 4097, 4096, 0);
    add_pixel(330, 8191, 20'hFFFFF, 0);
    add_pixel(10, 4096, 20'hFFFFF, 0);
    add_pixel(150, 2048, 4097, 0);
    add_pixel(210, 2048, 1044480, 0);
    add_pixel(250, 100, 0, 0);
    add_pixel(65520, 6000, 8000, 0);
    add_pixel(35000, 1234, 567890, 0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      add_random_pixel(gap_by_phase[(i * 4) / RANDOM_BEATS]);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pixels_pending.size() != 0 || start) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);

    if (failures == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

  // Driver: record the beat taken at this edge, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_rgb.push_back(predict_rgb(hue_degrees, saturation, brightness));
      end
      if (!start || !busy) begin
        if (pixels_pending.size() != 0 && $urandom_range(99) >= pixels_pending[0].gap_pct) begin
          next_pixel = pixels_pending.pop_front();
          start       <= 1'b1;
          hue_degrees <= next_pixel.hue;
          saturation  <= next_pixel.sat;
          brightness  <= next_pixel.val;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done beat is matched against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rgb.size() == 0) begin
        $error("result with none expected: red %0d green %0d blue %0d", red, green, blue);
        failures++;
      end else begin
        want_rgb = expected_rgb.pop_front();
        check_channel("red", want_rgb.red, red);
        check_channel("green", want_rgb.green, green);
        check_channel("blue", want_rgb.blue, blue);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
    end
  end

endmodule
